@@ hw/rtl/stbr_pkg.sv @@
// Shared types and constants for the STUN binding response parser.
package stbr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned CFG_AW   = 5;
    localparam int unsigned CFG_DW   = 64;
    localparam int unsigned OUT_DW   = 56;
    localparam int unsigned RES_W    = 49;
    localparam int unsigned HDR_LEN  = 20;

    localparam logic [POS_W-1:0] POS_CAP   = 17'd65556;
    localparam logic [POS_W-1:0] POS_HDR   = 17'd20;
    localparam logic [POS_W-1:0] POS_ID    = 17'd8;

    localparam logic [31:0] COOKIE_RESET   = 32'h2112_A442;

    localparam logic [15:0] MSG_BIND_OK    = 16'h0101;
    localparam logic [15:0] ATTR_XOR       = 16'h0020;
    localparam logic [15:0] ATTR_XOR_OLD   = 16'h8020;
    localparam logic [15:0] ATTR_MAPPED    = 16'h0001;
    localparam logic [7:0]  ADDR_FAMILY_V4 = 8'h01;
    localparam logic [7:0]  TOP_BITS_MASK  = 8'hc0;
    localparam logic [15:0] LEN_MASK       = 16'h0003;
    localparam logic [15:0] ADDR_MIN_LEN   = 16'd8;

    localparam logic [1:0]  REG_COOKIE     = 2'd0;
    localparam logic [1:0]  REG_ID_HIGH    = 2'd1;
    localparam logic [1:0]  REG_ID_LOW     = 2'd2;

    typedef enum logic [2:0] {
        ST_XOR_OK    = 3'd0,
        ST_PLAIN_OK  = 3'd1,
        ST_NOT_STUN  = 3'd2,
        ST_WRONG_TYP = 3'd3,
        ST_ID_BAD    = 3'd4,
        ST_NO_ADDR   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_HDR   = 2'd0,
        PH_VALUE = 2'd1,
        PH_PAD   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] cookie;
        logic [31:0] id_high;
        logic [63:0] id_low;
    } cfg_t;

    typedef struct packed {
        logic        found;
        status_t     status;
        logic [31:0] ipv4;
        logic [15:0] port;
    } res_t;

endpackage

@@ hw/rtl/stbr_cfg.sv @@
// Configuration register file with an APB-style access port.
module stbr_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [stbr_pkg::CFG_AW-1:0] paddr,
    input  logic [stbr_pkg::CFG_DW-1:0] pwdata,
    output logic [stbr_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output stbr_pkg::cfg_t             cfg
);
    import stbr_pkg::*;

    logic [31:0] cookie_reg;
    logic [31:0] id_high_reg;
    logic [63:0] id_low_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cookie_reg  <= COOKIE_RESET;
            id_high_reg <= '0;
            id_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_COOKIE:  cookie_reg  <= pwdata[31:0];
                REG_ID_HIGH: id_high_reg <= pwdata[31:0];
                REG_ID_LOW:  id_low_reg  <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COOKIE:  prdata = {32'd0, cookie_reg};
            REG_ID_HIGH: prdata = {32'd0, id_high_reg};
            REG_ID_LOW:  prdata = id_low_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.cookie  = cookie_reg;
    assign cfg.id_high = id_high_reg;
    assign cfg.id_low  = id_low_reg;

endmodule

@@ hw/rtl/stbr_parse.sv @@
// Per-datagram header check, attribute walk and result selection.
module stbr_parse
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [stbr_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_byte,
    input  stbr_pkg::cfg_t              cfg,
    output stbr_pkg::res_t              res
);
    import stbr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      type_reg, type_next;
    logic [15:0]      dlen_reg, dlen_next;
    logic [3:0]       flags_reg, flags_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      atype_reg, atype_next;
    logic [15:0]      alen_reg, alen_next;
    logic [15:0]      aoff_reg, aoff_next;
    logic [7:0]       fam_reg, fam_next;
    logic [15:0]      vport_reg, vport_next;
    logic [31:0]      vaddr_reg, vaddr_next;
    logic [RES_W-1:0] xres_reg, xres_next;
    logic [RES_W-1:0] pres_reg, pres_next;
    logic             stop_reg, stop_next;

    logic [127:0]     hdr_vec;
    logic [3:0]       hdr_k;
    logic [7:0]       exp_byte;
    logic [POS_W-1:0] total;
    logic [16:0]      off_inc;
    logic [15:0]      pad_inc;
    logic [1:0]       pad;
    logic             finish;
    logic             is_xor;
    logic             is_plain;
    logic [15:0]      mport;
    logic [31:0]      maddr;
    logic             addr_ok;
    logic             not_stun;

    assign hdr_vec  = {cfg.cookie, cfg.id_high, cfg.id_low};
    assign hdr_k    = pos_reg[3:0] - 4'd4;
    assign exp_byte = hdr_vec[{~hdr_k, 3'b000} +: 8];
    assign total    = POS_HDR + {1'b0, dlen_reg};
    assign off_inc  = {1'b0, aoff_reg} + 17'd1;
    assign pad_inc  = aoff_reg + 16'd1;
    assign pad      = 2'd0 - alen_reg[1:0];

    always_comb
    begin
        pos_next   = (pos_reg < POS_CAP) ? pos_reg + 17'd1 : pos_reg;
        type_next  = type_reg;
        dlen_next  = dlen_reg;
        flags_next = flags_reg;
        phase_next = phase_reg;
        atype_next = atype_reg;
        alen_next  = alen_reg;
        aoff_next  = aoff_reg;
        fam_next   = fam_reg;
        vport_next = vport_reg;
        vaddr_next = vaddr_reg;
        stop_next  = stop_reg;
        finish     = 1'b0;

        if (pos_reg < POS_HDR)
        begin
            case (pos_reg[4:0])
                5'd0:
                begin
                    if ((data_byte & TOP_BITS_MASK) != 8'd0)
                    begin
                        flags_next[0] = 1'b1;
                    end
                    type_next = {data_byte, 8'd0};
                end
                5'd1: type_next[7:0] = data_byte;
                5'd2: dlen_next = {data_byte, 8'd0};
                5'd3:
                begin
                    dlen_next[7:0] = data_byte;
                    if ((dlen_next & LEN_MASK) != 16'd0)
                    begin
                        flags_next[3] = 1'b1;
                    end
                end
                default:
                begin
                    if (exp_byte != data_byte)
                    begin
                        if (pos_reg < POS_ID)
                        begin
                            flags_next[1] = 1'b1;
                        end
                        else
                        begin
                            flags_next[2] = 1'b1;
                        end
                    end
                end
            endcase
        end
        else if ((pos_reg < POS_CAP) && !stop_reg)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    case (aoff_reg[1:0])
                        2'd0:    atype_next = {data_byte, 8'd0};
                        2'd1:    atype_next[7:0] = data_byte;
                        2'd2:    alen_next = {data_byte, 8'd0};
                        default: alen_next[7:0] = data_byte;
                    endcase
                    if (aoff_reg[1:0] != 2'd3)
                    begin
                        aoff_next = aoff_reg + 16'd1;
                    end
                    else
                    begin
                        aoff_next  = '0;
                        fam_next   = '0;
                        vport_next = '0;
                        vaddr_next = '0;
                        if ({1'b0, pos_reg} + 18'd1 + {2'b00, alen_next} > {1'b0, total})
                        begin
                            stop_next = 1'b1;
                        end
                        else if (alen_next != 16'd0)
                        begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    if (aoff_reg == 16'd1)
                    begin
                        fam_next = data_byte;
                    end
                    else if ((aoff_reg == 16'd2) || (aoff_reg == 16'd3))
                    begin
                        vport_next = {vport_reg[7:0], data_byte};
                    end
                    else if ((aoff_reg >= 16'd4) && (aoff_reg <= 16'd7))
                    begin
                        vaddr_next = {vaddr_reg[23:0], data_byte};
                    end
                    if (off_inc >= {1'b0, alen_reg})
                    begin
                        finish    = 1'b1;
                        aoff_next = '0;
                        phase_next = (alen_reg[1:0] != 2'd0) ? PH_PAD : PH_HDR;
                    end
                    else
                    begin
                        aoff_next = off_inc[15:0];
                    end
                end
                PH_PAD:
                begin
                    if (pad_inc >= {14'd0, pad})
                    begin
                        aoff_next  = '0;
                        phase_next = PH_HDR;
                    end
                    else
                    begin
                        aoff_next = pad_inc;
                    end
                end
                default: phase_next = PH_HDR;
            endcase
        end
    end

    assign is_xor   = (atype_reg == ATTR_XOR) || (atype_reg == ATTR_XOR_OLD);
    assign is_plain = (atype_reg == ATTR_MAPPED);
    assign mport    = is_xor ? (vport_next ^ cfg.cookie[31:16]) : vport_next;
    assign maddr    = is_xor ? (vaddr_next ^ cfg.cookie) : vaddr_next;
    assign addr_ok  = finish && (is_xor || is_plain) && (alen_reg >= ADDR_MIN_LEN)
                      && (fam_next == ADDR_FAMILY_V4) && (mport != 16'd0)
                      && (maddr != 32'd0);

    always_comb
    begin
        xres_next = xres_reg;
        pres_next = pres_reg;
        if (addr_ok && is_xor && !xres_reg[RES_W-1])
        begin
            xres_next = {1'b1, mport, maddr};
        end
        if (addr_ok && is_plain && !pres_reg[RES_W-1])
        begin
            pres_next = {1'b1, mport, maddr};
        end
    end

    assign not_stun = flags_next[3] || flags_next[1] || flags_next[0]
                      || (pos_next >= POS_CAP)
                      || (pos_next != POS_HDR + {1'b0, dlen_next});

    always_comb
    begin
        res.found  = 1'b0;
        res.ipv4   = '0;
        res.port   = '0;
        if (not_stun)
        begin
            res.status = ST_NOT_STUN;
        end
        else if (type_next != MSG_BIND_OK)
        begin
            res.status = ST_WRONG_TYP;
        end
        else if (flags_next[2])
        begin
            res.status = ST_ID_BAD;
        end
        else if (xres_next[RES_W-1])
        begin
            res.status = ST_XOR_OK;
            res.found  = 1'b1;
            res.port   = xres_next[47:32];
            res.ipv4   = xres_next[31:0];
        end
        else if (pres_next[RES_W-1])
        begin
            res.status = ST_PLAIN_OK;
            res.found  = 1'b1;
            res.port   = pres_next[47:32];
            res.ipv4   = pres_next[31:0];
        end
        else
        begin
            res.status = ST_NO_ADDR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            type_reg  <= '0;
            dlen_reg  <= '0;
            flags_reg <= '0;
            phase_reg <= PH_HDR;
            atype_reg <= '0;
            alen_reg  <= '0;
            aoff_reg  <= '0;
            fam_reg   <= '0;
            vport_reg <= '0;
            vaddr_reg <= '0;
            xres_reg  <= '0;
            pres_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                type_reg  <= '0;
                dlen_reg  <= '0;
                flags_reg <= '0;
                phase_reg <= PH_HDR;
                atype_reg <= '0;
                alen_reg  <= '0;
                aoff_reg  <= '0;
                fam_reg   <= '0;
                vport_reg <= '0;
                vaddr_reg <= '0;
                xres_reg  <= '0;
                pres_reg  <= '0;
                stop_reg  <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                type_reg  <= type_next;
                dlen_reg  <= dlen_next;
                flags_reg <= flags_next;
                phase_reg <= phase_next;
                atype_reg <= atype_next;
                alen_reg  <= alen_next;
                aoff_reg  <= aoff_next;
                fam_reg   <= fam_next;
                vport_reg <= vport_next;
                vaddr_reg <= vaddr_next;
                xres_reg  <= xres_next;
                pres_reg  <= pres_next;
                stop_reg  <= stop_next;
            end
        end
    end

endmodule

@@ hw/rtl/stun_binding_response_parser.sv @@
// Top level of the STUN binding response parser.
// The slave stream carries one UDP datagram as a sequence of byte words, with
// s_tlast high on the final byte. The master stream carries one result word
// per datagram, issued for the word that had s_tlast set.
// The user must write the registers (magic cookie and expected transaction id) over
// the APB-style port only while no datagram is in flight; the block does not enforce it.
// Each byte word is taken into an input register, then processed by the parser,
// so the sustained rate is one byte word per clock unless a stalled receiver holds the result register.
// A result appears on the master stream after its final byte word passes
// through the input register and then the result register.
// When the receiver stalls, the result register holds its word; the parser
// keeps taking bytes of the next datagram until that datagram's final byte
// needs the result register, and then s_tready drops until it is free.
// Reset clears the per-datagram state, empties both registers and restores
// the register defaults.
module stun_binding_response_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte
    input  logic                         s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [stbr_pkg::OUT_DW-1:0]  m_tdata,   // endpoint_found, parse_status,
                                                    // mapped_ipv4, mapped_port, zero fill
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stbr_pkg::CFG_AW-1:0]  paddr,
    input  logic [stbr_pkg::CFG_DW-1:0]  pwdata,
    output logic [stbr_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import stbr_pkg::*;

    cfg_t        cfg;
    res_t        res;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    logic        advance;

    stbr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stbr_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.port, out_res_reg.ipv4,
                       out_res_reg.status, out_res_reg.found};

endmodule
